>>> rtl/core/skewed_triangle_oscillator_assert.svh
// Assertion macros shared by the oscillator RTL
`ifndef SKEWED_TRIANGLE_OSCILLATOR_ASSERT_SVH
`define SKEWED_TRIANGLE_OSCILLATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define STOSC_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define STOSC_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/stosc_pkg.sv
// Types and constants of the skewed triangle oscillator
package stosc_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned LVL_W     = FRAC_BITS + 1;
  localparam int unsigned STEP_W    = 32;
  localparam int unsigned OFFS_W    = 16;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned DIV_STEPS = FRAC_BITS + 1;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

  localparam logic [LVL_W-1:0] ONE_Q  = LVL_W'(1) << FRAC_BITS;
  localparam logic [LVL_W-1:0] HALF_Q = LVL_W'(1) << (FRAC_BITS - 1);

  localparam logic [LVL_W-1:0] RISE_WIDTH_RST = HALF_Q;
  localparam logic [LVL_W-1:0] GAIN_RST       = ONE_Q;

  typedef enum logic [1:0] {
    REG_PHASE_STEP,
    REG_RISE_WIDTH,
    REG_GAIN,
    REG_PHASE_OFFSET
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_MUL,
    ST_DONE
  } state_t;

endpackage

>>> rtl/core/stosc_if.sv
// Request and result channel interfaces of the oscillator
interface stosc_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface stosc_out_if;
  logic                          valid;
  logic                          ready;
  logic [stosc_pkg::LVL_W-1:0]   level;
  logic                          rising;

  modport source (output valid, output level, output rising, input ready);
  modport sink   (input valid, input level, input rising, output ready);
endinterface

>>> rtl/core/skewed_triangle_oscillator.sv
// Skewed triangle oscillator: phase accumulator, shared divider, gain stage
//
// Usage: every request on in_req is one sample tick. restart = 0 advances the
// phase accumulator by phase_step; restart = 1 loads it from phase_offset
// (placed in the top 16 bits) without advancing. Each request yields exactly
// one result on out_res: level (unsigned Q16, 0..1) and rising.
// Configuration: cfg_we writes cfg_wdata into register cfg_idx (phase_step,
// rise_width, gain, phase_offset) at the clock edge; write only while idle.
// Sequence from the accepting edge to result valid: a step to select the
// dividend and divisor, the steps of the shared compare-subtract divider
// (one quotient bit a cycle), a multiply step and a step to round and clamp
// into the output register.
// Requests: the divider iterations dominate the time per request. The block
// takes no new request until the current one has reached the output register.
// Stall: the result sits in an output register; a new request is accepted
// while it waits, but a finished computation holds in its last step until the
// output register frees up.
// Reset (rst_n low, synchronous): accumulator cleared, registers to their
// defaults (step 0, width one half, gain one, offset 0), no result pending.
`include "skewed_triangle_oscillator_assert.svh"

module skewed_triangle_oscillator #(
  parameter int unsigned PHASE_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_idx,
  input  logic [stosc_pkg::CFG_W-1:0]   cfg_wdata,
  stosc_in_if.sink                      in_req,
  stosc_out_if.source                   out_res
);

  localparam int unsigned FB = stosc_pkg::FRAC_BITS;
  localparam int unsigned LW = stosc_pkg::LVL_W;
  localparam int unsigned CW = stosc_pkg::CNT_W;
  localparam int unsigned PW = 2 * LW - 1;   // product g*v fits, g,v <= ONE
  localparam int unsigned SW = PW + 1;       // rounding sum

  // Configuration registers
  logic [stosc_pkg::STEP_W-1:0] step_r;
  logic [LW-1:0]                width_r;
  logic [LW-1:0]                gain_r;
  logic [stosc_pkg::OFFS_W-1:0] offs_r;

  // Sequencer and datapath
  stosc_pkg::state_t state_r, state_nxt;
  logic [PHASE_BITS-1:0] acc_r, acc_nxt;
  logic                  up_r, up_nxt;
  logic [LW-1:0]         rem_r, rem_nxt;
  logic [LW-1:0]         div_r, div_nxt;
  logic [LW-1:0]         quo_r, quo_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [PW-1:0]         prod_r, prod_nxt;

  // Output register
  logic          out_valid_r, out_valid_nxt;
  logic [LW-1:0] out_level_r, out_level_nxt;
  logic          out_rising_r, out_rising_nxt;

  logic          in_acc;
  logic          out_free;
  logic          div_last;
  logic [FB-1:0] phase;
  logic [LW-1:0] w_clamp;
  logic [LW-1:0] g_clamp;
  logic          p_below;
  logic [LW:0]   trial;
  logic          fits;
  logic [SW-1:0] sum;
  logic [LW-1:0] lvl;

  assign in_req.ready   = (state_r == stosc_pkg::ST_IDLE);
  assign in_acc         = in_req.valid && in_req.ready;
  assign out_free       = !out_valid_r || out_res.ready;
  assign div_last       = (cnt_r == CW'(stosc_pkg::DIV_STEPS - 1));

  assign out_res.valid  = out_valid_r;
  assign out_res.level  = out_level_r;
  assign out_res.rising = out_rising_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= '0;
      width_r <= stosc_pkg::RISE_WIDTH_RST;
      gain_r  <= stosc_pkg::GAIN_RST;
      offs_r  <= '0;
    end else if (cfg_we) begin
      case (stosc_pkg::cfg_reg_t'(cfg_idx))
        stosc_pkg::REG_PHASE_STEP:   step_r  <= cfg_wdata[stosc_pkg::STEP_W-1:0];
        stosc_pkg::REG_RISE_WIDTH:   width_r <= cfg_wdata[LW-1:0];
        stosc_pkg::REG_GAIN:         gain_r  <= cfg_wdata[LW-1:0];
        stosc_pkg::REG_PHASE_OFFSET: offs_r  <= cfg_wdata[stosc_pkg::OFFS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Phase in Q16 from the top of the accumulator; clamp width and gain to one
  assign phase   = acc_r[PHASE_BITS-1 -: FB];
  assign w_clamp = (width_r > stosc_pkg::ONE_Q) ? stosc_pkg::ONE_Q : width_r;
  assign g_clamp = (gain_r > stosc_pkg::ONE_Q) ? stosc_pkg::ONE_Q : gain_r;
  assign p_below = {1'b0, phase} < w_clamp;

  // Shared compare-subtract unit: the first step weighs 2^16 and takes the
  // remainder as it is, later steps double it first
  assign trial = (cnt_r == '0) ? {1'b0, rem_r} : {rem_r, 1'b0};
  assign fits  = trial >= {1'b0, div_r};

  // Round to nearest, tie up: (g*v + (ONE-g)*HALF + HALF) >> FRAC_BITS
  assign sum = SW'(prod_r)
             + (SW'(stosc_pkg::ONE_Q - g_clamp) << (FB - 1))
             + SW'(stosc_pkg::HALF_Q);
  assign lvl = (sum[SW-1:FB] > (SW-FB)'(stosc_pkg::ONE_Q))
             ? stosc_pkg::ONE_Q : sum[FB +: LW];

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      stosc_pkg::ST_IDLE: if (in_acc)   state_nxt = stosc_pkg::ST_PREP;
      stosc_pkg::ST_PREP:               state_nxt = stosc_pkg::ST_DIV;
      stosc_pkg::ST_DIV:  if (div_last) state_nxt = stosc_pkg::ST_MUL;
      stosc_pkg::ST_MUL:                state_nxt = stosc_pkg::ST_DONE;
      stosc_pkg::ST_DONE: if (out_free) state_nxt = stosc_pkg::ST_IDLE;
      default:                          state_nxt = stosc_pkg::ST_IDLE;
    endcase
  end

  // Datapath and output register
  always_comb begin
    acc_nxt        = acc_r;
    up_nxt         = up_r;
    rem_nxt        = rem_r;
    div_nxt        = div_r;
    quo_nxt        = quo_r;
    cnt_nxt        = cnt_r;
    prod_nxt       = prod_r;
    out_level_nxt  = out_level_r;
    out_rising_nxt = out_rising_r;
    out_valid_nxt  = out_valid_r && !out_res.ready;
    case (state_r)
      stosc_pkg::ST_IDLE: begin
        if (in_acc) begin
          // reload from the offset, or advance one tick; wrap is free
          acc_nxt = in_req.restart
                  ? (PHASE_BITS'(offs_r) << (PHASE_BITS - stosc_pkg::OFFS_W))
                  : acc_r + PHASE_BITS'(step_r);
        end
      end
      stosc_pkg::ST_PREP: begin
        // rising: p/w; falling: (ONE-p)/(ONE-w); divisor is never zero
        up_nxt  = p_below;
        rem_nxt = p_below ? {1'b0, phase} : stosc_pkg::ONE_Q - {1'b0, phase};
        div_nxt = p_below ? w_clamp : stosc_pkg::ONE_Q - w_clamp;
        quo_nxt = '0;
        cnt_nxt = '0;
      end
      stosc_pkg::ST_DIV: begin
        rem_nxt = fits ? LW'(trial - {1'b0, div_r}) : trial[LW-1:0];
        quo_nxt = {quo_r[LW-2:0], fits};
        cnt_nxt = cnt_r + CW'(1);
      end
      stosc_pkg::ST_MUL: begin
        prod_nxt = PW'(g_clamp * quo_r);
      end
      stosc_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_level_nxt  = lvl;
          out_rising_nxt = up_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= stosc_pkg::ST_IDLE;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    up_r         <= up_nxt;
    rem_r        <= rem_nxt;
    div_r        <= div_nxt;
    quo_r        <= quo_nxt;
    cnt_r        <= cnt_nxt;
    prod_r       <= prod_nxt;
    out_level_r  <= out_level_nxt;
    out_rising_r <= out_rising_nxt;
  end

  // Divisor never zero while dividing
  `STOSC_ASSERT_NOW(a_div_nonzero, clk, rst_n, state_r == stosc_pkg::ST_DIV, div_r != '0, "divider running with a zero divisor")
  // Partial remainder stays within the divisor
  `STOSC_ASSERT_NOW(a_rem_bound, clk, rst_n, state_r == stosc_pkg::ST_DIV, rem_r <= div_r, "partial remainder above divisor")
  // Quotient never exceeds one
  `STOSC_ASSERT_NOW(a_quo_bound, clk, rst_n, state_r == stosc_pkg::ST_MUL, quo_r <= stosc_pkg::ONE_Q, "waveform value above one")
  // An accepted request starts the sequence
  `STOSC_ASSERT_NEXT(a_start, clk, rst_n, in_acc, state_r == stosc_pkg::ST_PREP, "request accepted but sequencer did not start")
  // Last divider step hands over to the multiply
  `STOSC_ASSERT_NEXT(a_div_end, clk, rst_n, state_r == stosc_pkg::ST_DIV && div_last, state_r == stosc_pkg::ST_MUL, "divider overran its step count")

endmodule

>>> test/skewed_triangle_oscillator_tb.sv
// Self-checking testbench for the skewed triangle oscillator
module skewed_triangle_oscillator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import stosc_pkg::*;

  // Q16 unity and one half, held wide so that products never overflow
  localparam longint unsigned UNITY = 64'd1 << FRAC_BITS;
  localparam longint unsigned HALF  = UNITY >> 1;

  // Random part: phases of fixed settings, each a run of sample ticks
  localparam int PHASES      = 17;
  localparam int PHASE_TICKS = 100;
  localparam int SETTLE      = 40;
  localparam int unsigned CYCLE_LIMIT = 600_000;
  localparam int REPORT_MAX  = 10;

  typedef struct packed {
    logic [LVL_W-1:0] level;
    logic             rising;
  } osc_sample_t;

  // One row of the directed table: either a register write or a sample tick.
  // pinned rows carry a result read straight off the waveform definition.
  typedef struct packed {
    logic             wr;
    cfg_reg_t         idx;
    logic [CFG_W-1:0] data;
    logic             restart;
    logic             pinned;
    logic [LVL_W-1:0] level;
    logic             rising;
  } stim_row_t;

  localparam int DIR_N = 27;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [1:0] cfg_idx;
  logic [CFG_W-1:0] cfg_wdata;

  stosc_in_if  req_ch();
  stosc_out_if res_ch();

  // Pinned expectation travelling alongside the request being offered
  logic             pin_valid;
  logic [LVL_W-1:0] pin_level;
  logic             pin_rising;

  // Shadow copy of the oscillator: registers and phase accumulator
  logic [STEP_W-1:0] step_sh;
  logic [LVL_W-1:0]  width_sh;
  logic [LVL_W-1:0]  gain_sh;
  logic [OFFS_W-1:0] offset_sh;
  logic [STEP_W-1:0] phase_acc;

  osc_sample_t pending_samples[$];
  osc_sample_t seen;
  osc_sample_t want;

  int unsigned fail_cnt;
  int unsigned result_cnt;
  int unsigned cycle_cnt;
  bit          send_calm;
  bit          recv_calm;
  bit          busy;

  stim_row_t directed [0:DIR_N-1];

  skewed_triangle_oscillator i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_req    (req_ch),
    .out_res   (res_ch)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Advance the shadow accumulator by one tick and work out the sample it gives.
  // Rising while the phase sits below the width, falling from the width on;
  // width and gain above one count as one.
  function automatic osc_sample_t advance_oscillator(input logic restart);
    longint unsigned p, w, g, v, lvl;
    logic            up;
    osc_sample_t     s;
    if (restart) begin
      phase_acc = {offset_sh, 16'h0000};
    end else begin
      phase_acc = phase_acc + step_sh;
    end
    p  = longint'(phase_acc[STEP_W-1 -: FRAC_BITS]);
    w  = (longint'(width_sh) > UNITY) ? UNITY : longint'(width_sh);
    g  = (longint'(gain_sh) > UNITY) ? UNITY : longint'(gain_sh);
    up = (p < w);
    if (up) begin
      v = (p * UNITY) / w;
    end else begin
      v = ((UNITY - p) * UNITY) / (UNITY - w);
    end
    if (v > UNITY) v = UNITY;
    // round to nearest, ties upward
    lvl = (g * v + (UNITY - g) * HALF + HALF) >> FRAC_BITS;
    if (lvl > UNITY) lvl = UNITY;
    s.level  = lvl[LVL_W-1:0];
    s.rising = up;
    return s;
  endfunction

  // Mostly a random wait, sometimes none; a calm stretch never waits
  function automatic int unsigned draw_wait(input bit calm);
    if (calm || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 18);
  endfunction

  function automatic logic [CFG_W-1:0] pick_step();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return 32'hFFFF_FFFF;
      2:       return CFG_W'($urandom_range(1, 1 << 22));
      default: return $urandom();
    endcase
  endfunction

  // Width and gain: edges of the Q16 range, values beyond one, and the rest
  function automatic logic [CFG_W-1:0] pick_fraction();
    case ($urandom_range(0, 6))
      0:       return '0;
      1:       return CFG_W'(UNITY);
      2:       return CFG_W'($urandom_range(65537, 131071));
      3:       return CFG_W'($urandom_range(0, 1) ? 1 : 65535);
      default: return CFG_W'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_offset();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return CFG_W'(16'hFFFF);
      default: return CFG_W'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic note_fail(input string msg);
    fail_cnt++;
    if (fail_cnt <= REPORT_MAX) $display("%s", msg);
  endtask

  // Offer one sample tick and hold it until the block takes the request.
  // With no gap the valid stays high from the previous request.
  task automatic send_tick(input logic restart, input logic pinned,
                           input logic [LVL_W-1:0] lvl, input logic up);
    int unsigned gap;
    gap = draw_wait(send_calm);
    cfg_we <= 1'b0;
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.restart <= restart;
    pin_valid      <= pinned;
    pin_level      <= lvl;
    pin_rising     <= up;
    do @(posedge clk); while (!req_ch.ready);
    busy = 1'b1;
  endtask

  // Drop the request and wait until every expected sample has come back,
  // so that a register write lands on an idle block
  task automatic drain_samples();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_samples.size() != 0) @(posedge clk);
    busy = 1'b0;
  endtask

  task automatic cfg_write(input cfg_reg_t idx, input logic [CFG_W-1:0] data);
    if (busy) drain_samples();
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // Shadow the register writes, predict every accepted request and check
  // every accepted result against the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      step_sh   <= '0;
      width_sh  <= 17'd32768;
      gain_sh   <= 17'd65536;
      offset_sh <= '0;
      phase_acc <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_idx))
          REG_PHASE_STEP:   step_sh   <= cfg_wdata[STEP_W-1:0];
          REG_RISE_WIDTH:   width_sh  <= cfg_wdata[LVL_W-1:0];
          REG_GAIN:         gain_sh   <= cfg_wdata[LVL_W-1:0];
          REG_PHASE_OFFSET: offset_sh <= cfg_wdata[OFFS_W-1:0];
          default: ;
        endcase
      end
      if (req_ch.valid && req_ch.ready) begin
        want = advance_oscillator(req_ch.restart);
        // a pinned row replaces the prediction with its own typed result
        if (pin_valid) begin
          want.level  = pin_level;
          want.rising = pin_rising;
        end
        pending_samples.push_back(want);
      end
      if (res_ch.valid && res_ch.ready) begin
        seen.level  = res_ch.level;
        seen.rising = res_ch.rising;
        if (pending_samples.size() == 0) begin
          note_fail($sformatf("result %0d with nothing expected: level %0d rising %0b",
                              result_cnt, seen.level, seen.rising));
        end else begin
          want = pending_samples.pop_front();
          if (seen !== want) begin
            note_fail($sformatf(
              "result %0d: expected level %0d rising %0b, got level %0d rising %0b",
              result_cnt, want.level, want.rising, seen.level, seen.rising));
          end
        end
        result_cnt++;
      end
    end
  end

  // Hard stop should the block hang
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Result side: stall for a random number of cycles before each result
  initial begin
    int unsigned stall;
    res_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = draw_wait(recv_calm);
      if (stall != 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
    end
  end

  // Directed table. Pinned results after reset (step 0, width one half, gain
  // one) and at the extremes; the stepping rows go to the predictor.
  initial begin
    directed = '{
      // reset state: phase zero, bottom of the rise
      '{1'b0, REG_PHASE_STEP,   32'h0,         1'b0, 1'b1, 17'd0,     1'b1},
      '{1'b0, REG_PHASE_STEP,   32'h0,         1'b1, 1'b1, 17'd0,     1'b1},
      // phase exactly at the width counts as falling, at the top
      '{1'b1, REG_PHASE_OFFSET, 32'h8000,      1'b0, 1'b0, 17'd0,     1'b0},
      '{1'b0, REG_PHASE_STEP,   32'h0,         1'b1, 1'b1, 17'd65536, 1'b0},
      // last phase step before wrapping
      '{1'b1, REG_PHASE_OFFSET, 32'hFFFF,      1'b0, 1'b0, 17'd0,     1'b0},
      '{1'b0, REG_PHASE_STEP,   32'h0,         1'b1, 1'b1, 17'd2,     1'b0},
      // zero gain parks the output at one half
      '{1'b1, REG_GAIN,         32'h0,         1'b0, 1'b0, 17'd0,     1'b0},
      '{1'b0, REG_PHASE_STEP,   32'h0,         1'b1, 1'b1, 17'd32768, 1'b0},
      // gain above one clamps to one
      '{1'b1, REG_GAIN,         32'h1FFFF,     1'b0, 1'b0, 17'd0,     1'b0},
      '{1'b0, REG_PHASE_STEP,   32'h0,         1'b1, 1'b1, 17'd2,     1'b0},
      // zero width: always falling, from the top
      '{1'b1, REG_RISE_WIDTH,   32'h0,         1'b0, 1'b0, 17'd0,     1'b0},
      '{1'b1, REG_PHASE_OFFSET, 32'h0,         1'b0, 1'b0, 17'd0,     1'b0},
      '{1'b0, REG_PHASE_STEP,   32'h0,         1'b1, 1'b1, 17'd65536, 1'b0},
      // width above one clamps to one: always rising
      '{1'b1, REG_RISE_WIDTH,   32'h1FFFF,     1'b0, 1'b0, 17'd0,     1'b0},
      '{1'b0, REG_PHASE_STEP,   32'h0,         1'b1, 1'b1, 17'd0,     1'b1},
      '{1'b1, REG_PHASE_OFFSET, 32'hFFFF,      1'b0, 1'b0, 17'd0,     1'b0},
      '{1'b0, REG_PHASE_STEP,   32'h0,         1'b1, 1'b1, 17'd65535, 1'b1},
      // full-scale step: the accumulator wraps every tick
      '{1'b1, REG_PHASE_STEP,   32'hFFFF_FFFF, 1'b0, 1'b0, 17'd0,     1'b0},
      '{1'b0, REG_PHASE_STEP,   32'h0,         1'b0, 1'b0, 17'd0,     1'b0},
      '{1'b0, REG_PHASE_STEP,   32'h0,         1'b0, 1'b0, 17'd0,     1'b0},
      // skewed shape at half gain, sixteen ticks per cycle
      '{1'b1, REG_RISE_WIDTH,   32'd16384,     1'b0, 1'b0, 17'd0,     1'b0},
      '{1'b1, REG_GAIN,         32'd32768,     1'b0, 1'b0, 17'd0,     1'b0},
      '{1'b1, REG_PHASE_STEP,   32'h1000_0000, 1'b0, 1'b0, 17'd0,     1'b0},
      '{1'b0, REG_PHASE_STEP,   32'h0,         1'b0, 1'b0, 17'd0,     1'b0},
      '{1'b0, REG_PHASE_STEP,   32'h0,         1'b0, 1'b0, 17'd0,     1'b0},
      '{1'b0, REG_PHASE_STEP,   32'h0,         1'b0, 1'b0, 17'd0,     1'b0},
      '{1'b0, REG_PHASE_STEP,   32'h0,         1'b1, 1'b0, 17'd0,     1'b0}
    };
  end

  // Stimulus: reset, directed table, then phases of random settings
  initial begin
    logic [CFG_W-1:0] step_v, width_v, gain_v, offset_v;
    fail_cnt       = 0;
    result_cnt     = 0;
    cycle_cnt      = 0;
    busy           = 1'b0;
    send_calm      = 1'b0;
    recv_calm      = 1'b0;
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_idx        <= '0;
    cfg_wdata      <= '0;
    req_ch.valid   <= 1'b0;
    req_ch.restart <= 1'b0;
    pin_valid      <= 1'b0;
    pin_level      <= '0;
    pin_rising     <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < DIR_N; r++) begin
      if (directed[r].wr) begin
        cfg_write(directed[r].idx, directed[r].data);
      end else begin
        send_tick(directed[r].restart, directed[r].pinned,
                  directed[r].level, directed[r].rising);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      // open with all-minimum settings, then all-maximum, then random mixes
      if (ph == 0) begin
        step_v = '0;
        width_v = '0;
        gain_v = '0;
        offset_v = '0;
      end else if (ph == 1) begin
        step_v = 32'hFFFF_FFFF;
        width_v = 32'h1FFFF;
        gain_v = 32'h1FFFF;
        offset_v = 32'hFFFF;
      end else begin
        step_v = pick_step();
        width_v = pick_fraction();
        gain_v = pick_fraction();
        offset_v = pick_offset();
      end
      cfg_write(REG_PHASE_STEP, step_v);
      cfg_write(REG_RISE_WIDTH, width_v);
      cfg_write(REG_GAIN, gain_v);
      cfg_write(REG_PHASE_OFFSET, offset_v);
      // some phases run back to back on one side or both
      send_calm = ($urandom_range(0, 3) == 0);
      recv_calm = ($urandom_range(0, 3) == 0);
      for (int t = 0; t < PHASE_TICKS; t++) begin
        send_tick(($urandom_range(0, 15) == 0), 1'b0, '0, 1'b0);
      end
    end

    drain_samples();
    repeat (SETTLE) @(posedge clk);
    if (pending_samples.size() != 0) begin
      note_fail($sformatf("%0d expected results never arrived", pending_samples.size()));
    end
    if (fail_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
